[hw/rtl/hmean_pkg.sv]
// shared types and constants of the harmonic mean fraction unit
`timescale 1ns / 1ps
`default_nettype none
package hmean_pkg;

  localparam int unsigned MAX_COUNT = 128;
  localparam int unsigned CNT_W     = $clog2(MAX_COUNT + 1);
  localparam int unsigned ADDR_W    = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned RES_W     = 63;
  localparam int unsigned DIV_W     = 64;
  localparam int unsigned PROD_W    = DIV_W + VAL_W;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_GCD_INIT,
    OP_GCD_STEP,
    OP_MUL_PART,
    OP_LCM_UPD,
    OP_SET_OVF,
    OP_SUM_INIT,
    OP_SUM_ACC,
    OP_MUL_SCALE,
    OP_SCALE_CHK,
    OP_NUM,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    DSEL_GCD,
    DSEL_PART,
    DSEL_TERM,
    DSEL_NUM,
    DSEL_DEN
  } dsel_e;

  typedef struct packed {
    op_e   op;
    logic  div_start;
    dsel_e div_sel;
  } cmd_t;

  typedef struct packed {
    logic lcm_go;
    logic last;
    logic y_zero;
    logic div_busy;
    logic ovf;
    logic idx_end;
    logic cnt_zero;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[hw/rtl/hmean_div.sv]
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module hmean_div
  import hmean_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DIV_W-1:0] divisor_i,
  output logic                  busy_o,
  output logic [DIV_W-1:0]      quo_o,
  output logic [DIV_W-1:0]      rem_o
);

  localparam int unsigned STEP_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  quo_q, rem_q, dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic [DIV_W-1:0]  trial;
  logic              fits;

  // operands stay below 2^63 so the shifted remainder fits the word
  assign trial = {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
  assign fits  = (trial >= dvs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(DIV_W);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? (trial - dvs_q) : trial;
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

[hw/rtl/hmean_dp.sv]
// datapath: value store, lcm, sum, multiplier, divider and result register
`timescale 1ns / 1ps
`default_nettype none
module hmean_dp
  import hmean_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  input  wire logic [VAL_W-1:0] value_i,
  input  wire logic             last_i,
  output status_t               status_o,
  output logic                  m_valid_o,
  input  wire logic             m_ready_i,
  output logic [RES_W-1:0]      m_num_o,
  output logic [RES_W-1:0]      m_den_o,
  output logic                  m_ovf_o
);

  localparam logic [DIV_W-1:0] LIM = {1'b0, {(DIV_W-1){1'b1}}};

  logic [VAL_W-1:0]  mem [MAX_COUNT];
  logic [VAL_W-1:0]  rd_q;
  logic [CNT_W-1:0]  cnt_q, idx_q;
  logic [RES_W-1:0]  lcm_q, num_q;
  logic              ovf_q, stored_q, last_q;
  logic [VAL_W-1:0]  v_q;
  logic [DIV_W-1:0]  x_q, y_q, sum_q, sum_nx;
  logic [PROD_W-1:0] prod_q, mul_a, mul_b;
  logic              m_valid_q, m_ovf_q;
  logic [RES_W-1:0]  m_num_q, m_den_q;
  logic              full, bad;
  logic [DIV_W-1:0]  dvd, dvs, quo, rem;
  logic              div_busy;

  assign full = (cnt_q == CNT_W'(MAX_COUNT));
  assign bad  = (value_i == '0) || full;

  always_comb begin
    unique case (cmd_i.div_sel)
      DSEL_GCD:  begin dvd = x_q;                   dvs = y_q; end
      DSEL_PART: begin dvd = {1'b0, lcm_q};         dvs = x_q; end
      DSEL_TERM: begin dvd = {1'b0, lcm_q};         dvs = DIV_W'(rd_q); end
      DSEL_NUM:  begin dvd = prod_q[DIV_W-1:0];     dvs = x_q; end
      DSEL_DEN:  begin dvd = sum_q;                 dvs = x_q; end
      default:   begin dvd = x_q;                   dvs = y_q; end
    endcase
  end

  hmean_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .busy_o     (div_busy),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  // one shared multiplier: quotient times value, or lcm times count
  always_comb begin
    if (cmd_i.op == OP_MUL_SCALE) begin
      mul_a = PROD_W'(lcm_q);
      mul_b = PROD_W'(cnt_q);
    end else begin
      mul_a = PROD_W'(quo);
      mul_b = PROD_W'(v_q);
    end
  end

  assign sum_nx = sum_q + quo;

  always_ff @(posedge clk_i) begin
    rd_q <= mem[idx_q[ADDR_W-1:0]];
    if (cmd_i.op == OP_LOAD && !bad) mem[cnt_q[ADDR_W-1:0]] <= value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      lcm_q     <= RES_W'(1);
      ovf_q     <= 1'b0;
      stored_q  <= 1'b0;
      last_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= (cmd_i.op == OP_EMIT) || (m_valid_q && !m_ready_i);
      unique case (cmd_i.op)
        OP_LOAD: begin
          last_q   <= last_i;
          stored_q <= !bad;
          if (bad) ovf_q <= 1'b1;
          else     cnt_q <= cnt_q + CNT_W'(1);
        end
        OP_LCM_UPD: begin
          if (prod_q[PROD_W-1:RES_W] != '0) ovf_q <= 1'b1;
          else                             lcm_q <= prod_q[RES_W-1:0];
        end
        OP_SET_OVF: ovf_q <= 1'b1;
        OP_SUM_ACC: if (sum_nx[DIV_W-1]) ovf_q <= 1'b1;
        OP_SCALE_CHK: if (prod_q[PROD_W-1:RES_W] != '0) ovf_q <= 1'b1;
        OP_EMIT: begin
          cnt_q     <= '0;
          lcm_q     <= RES_W'(1);
          ovf_q     <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD:      v_q <= value_i;
      OP_GCD_INIT:  begin x_q <= {1'b0, lcm_q}; y_q <= DIV_W'(v_q); end
      OP_GCD_STEP:  begin x_q <= y_q; y_q <= rem; end
      OP_MUL_PART:  prod_q <= mul_a * mul_b;
      OP_MUL_SCALE: prod_q <= mul_a * mul_b;
      OP_SUM_INIT:  begin sum_q <= '0; idx_q <= '0; end
      OP_SUM_ACC:   begin sum_q <= sum_nx; idx_q <= idx_q + CNT_W'(1); end
      OP_SCALE_CHK: begin x_q <= sum_q; y_q <= prod_q[DIV_W-1:0]; end
      OP_NUM:       num_q <= quo[RES_W-1:0];
      OP_EMIT: begin
        m_ovf_q <= ovf_q;
        m_num_q <= ovf_q ? '0 : num_q;
        m_den_q <= ovf_q ? '0 : quo[RES_W-1:0];
      end
      default: ;
    endcase
  end

  assign status_o.lcm_go   = stored_q && !ovf_q;
  assign status_o.last     = last_q;
  assign status_o.y_zero   = (y_q == '0);
  assign status_o.div_busy = div_busy;
  assign status_o.ovf      = ovf_q;
  assign status_o.idx_end  = (idx_q == cnt_q);
  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.out_free = !m_valid_q || m_ready_i;

  assign m_valid_o = m_valid_q;
  assign m_num_o   = m_num_q;
  assign m_den_o   = m_den_q;
  assign m_ovf_o   = m_ovf_q;

`ifndef SYNTHESIS
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy)
    else $error("divider started while busy");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_COUNT))
    else $error("count beyond store depth");
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_ovf_q) |-> (m_num_q == '0 && m_den_q == '0))
    else $error("overflow result carries a fraction");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EMIT) |-> (!m_valid_q || m_ready_i))
    else $error("result overwritten before taken");
`endif

endmodule
`default_nettype wire

[hw/rtl/hmean_ctrl.sv]
// controller state machine sequencing load, gcd, sum and reduction
`timescale 1ns / 1ps
`default_nettype none
module hmean_ctrl
  import hmean_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_ITEM, S_GCD, S_GCD_WAIT, S_PART_WAIT, S_LCM_UPD, S_FIN,
    S_SUM_NEXT, S_SUM_RD, S_SUM_WAIT, S_SCALE, S_CHK, S_NUM_WAIT,
    S_DEN_WAIT, S_OUT
  } state_e;

  state_e state_q;
  logic   fin_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o = '{op: OP_NONE, div_start: 1'b0, div_sel: DSEL_GCD};
    unique case (state_q)
      S_IDLE:      if (in_valid_i) cmd_o.op = OP_LOAD;
      S_ITEM:      if (status_i.lcm_go) cmd_o.op = OP_GCD_INIT;
      S_GCD: begin
        cmd_o.div_start = 1'b1;
        if (status_i.y_zero) cmd_o.div_sel = fin_q ? DSEL_NUM : DSEL_PART;
      end
      S_GCD_WAIT:  if (!status_i.div_busy) cmd_o.op = OP_GCD_STEP;
      S_PART_WAIT: if (!status_i.div_busy) cmd_o.op = OP_MUL_PART;
      S_LCM_UPD:   cmd_o.op = OP_LCM_UPD;
      S_FIN:       cmd_o.op = (status_i.ovf || status_i.cnt_zero) ? OP_SET_OVF : OP_SUM_INIT;
      S_SUM_NEXT:  if (!status_i.ovf && status_i.idx_end) cmd_o.op = OP_MUL_SCALE;
      S_SUM_RD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DSEL_TERM;
      end
      S_SUM_WAIT:  if (!status_i.div_busy) cmd_o.op = OP_SUM_ACC;
      S_SCALE:     cmd_o.op = OP_SCALE_CHK;
      S_CHK:       ;
      S_NUM_WAIT: begin
        if (!status_i.div_busy) begin
          cmd_o.op        = OP_NUM;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DSEL_DEN;
        end
      end
      S_DEN_WAIT:  ;
      S_OUT:       if (status_i.out_free) cmd_o.op = OP_EMIT;
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE:      if (in_valid_i) state_q <= S_ITEM;
        S_ITEM: begin
          if (status_i.lcm_go)    state_q <= S_GCD;
          else if (status_i.last) state_q <= S_FIN;
          else                    state_q <= S_IDLE;
        end
        S_GCD: begin
          if (!status_i.y_zero) state_q <= S_GCD_WAIT;
          else if (fin_q)       state_q <= S_NUM_WAIT;
          else                  state_q <= S_PART_WAIT;
        end
        S_GCD_WAIT:  if (!status_i.div_busy) state_q <= S_GCD;
        S_PART_WAIT: if (!status_i.div_busy) state_q <= S_LCM_UPD;
        S_LCM_UPD:   state_q <= status_i.last ? S_FIN : S_IDLE;
        S_FIN: begin
          if (status_i.ovf || status_i.cnt_zero) state_q <= S_OUT;
          else begin
            state_q <= S_SUM_NEXT;
            fin_q   <= 1'b1;
          end
        end
        S_SUM_NEXT: begin
          if (status_i.ovf)          state_q <= S_OUT;
          else if (status_i.idx_end) state_q <= S_SCALE;
          else                       state_q <= S_SUM_RD;
        end
        S_SUM_RD:    state_q <= S_SUM_WAIT;
        S_SUM_WAIT:  if (!status_i.div_busy) state_q <= S_SUM_NEXT;
        S_SCALE:     state_q <= S_CHK;
        S_CHK:       state_q <= status_i.ovf ? S_OUT : S_GCD;
        S_NUM_WAIT:  if (!status_i.div_busy) state_q <= S_DEN_WAIT;
        S_DEN_WAIT:  if (!status_i.div_busy) state_q <= S_OUT;
        S_OUT: begin
          if (status_i.out_free) begin
            state_q <= S_IDLE;
            fin_q   <= 1'b0;
          end
        end
        default:     state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/harmonic_mean_exact_fraction_unit.sv]
// an item runs one divide per euclid step of gcd(lcm, value), then one divide for the
// lcm update (none when the value is dropped or the set has overflowed); the closing item
// adds one divide per stored value, the final gcd steps and two divides for the reduction,
// all on the single 64-bit divider that retires one quotient bit per cycle; one item at a time
// a finished result waits in the output register while the next item is taken
// reset (async, active low) clears the count, sets the lcm to one, drops any result
`timescale 1ns / 1ps
`default_nettype none
module harmonic_mean_exact_fraction_unit
  import hmean_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  wire logic [15:0]   s_axis_tdata_i,   // value[15:0]
  input  wire logic          s_axis_tlast_i,   // last
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  output logic [127:0]       m_axis_tdata_o,   // numerator[62:0], denominator[125:63], zeros
  output logic               m_axis_tuser_o    // overflow
);

  cmd_t             cmd;
  status_t          status;
  logic [RES_W-1:0] num, den;

  hmean_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hmean_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .value_i   (s_axis_tdata_i),
    .last_i    (s_axis_tlast_i),
    .status_o  (status),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_num_o   (num),
    .m_den_o   (den),
    .m_ovf_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {2'b00, den, num};

endmodule
`default_nettype wire

[sim/tb_top.sv]
// self-checking testbench of the harmonic mean fraction unit
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import hmean_pkg::*;

  localparam longint unsigned LIM63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned N_ITEMS = 1700;
  localparam longint unsigned CYCLE_LIMIT = 64'd60_000_000;

  typedef struct {
    bit [RES_W-1:0] num;
    bit [RES_W-1:0] den;
    bit             ovf;
  } frac_t;

  function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
    longint unsigned r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return (x != 0) ? x : 64'd1;
  endfunction

  class hmean_scoreboard;
    bit [VAL_W-1:0]  vals[MAX_COUNT];
    int unsigned     cnt;
    longint unsigned lcm;
    bit              ovf_seen;
    frac_t           pending[$];
    int unsigned     mismatches;

    function new();
      cnt = 0;
      lcm = 1;
      ovf_seen = 0;
      mismatches = 0;
    endfunction

    function void note_input(bit [VAL_W-1:0] v, bit last);
      longint unsigned part, sum, term, scaled, g;
      frac_t           f;
      bit              ovf;
      if (v == 0) begin
        ovf_seen = 1;
      end else if (cnt >= MAX_COUNT) begin
        ovf_seen = 1;
      end else begin
        vals[cnt] = v;
        cnt++;
        if (!ovf_seen) begin
          part = lcm / euclid_gcd(lcm, v);
          if (part > LIM63 / v) ovf_seen = 1;
          else lcm = part * v;
        end
      end
      if (!last) return;
      ovf = ovf_seen || (cnt == 0);
      f.num = '0;
      f.den = '0;
      if (!ovf) begin
        sum = 0;
        for (int i = 0; i < cnt; i++) begin
          term = lcm / vals[i];
          if (term > LIM63 - sum) begin
            ovf = 1;
            break;
          end
          sum += term;
        end
        if (!ovf && lcm > LIM63 / cnt) ovf = 1;
        if (!ovf) begin
          scaled = lcm * cnt;
          g = euclid_gcd(sum, scaled);
          f.num = RES_W'(scaled / g);
          f.den = RES_W'(sum / g);
        end
      end
      f.ovf = ovf;
      pending.push_back(f);
      cnt = 0;
      lcm = 1;
      ovf_seen = 0;
    endfunction

    function void check_result(bit [RES_W-1:0] num, bit [RES_W-1:0] den, bit ovf);
      frac_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result num=%0d den=%0d ovf=%0b", num, den, ovf);
        return;
      end
      e = pending.pop_front();
      if (e.num !== num || e.den !== den || e.ovf !== ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected num=%0d den=%0d ovf=%0b, got num=%0d den=%0d ovf=%0b",
                   e.num, e.den, e.ovf, num, den, ovf);
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [15:0]  s_axis_tdata_i;
  logic         s_axis_tlast_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [127:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;

  harmonic_mean_exact_fraction_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  hmean_scoreboard sb = new();
  bit              no_gaps;
  int unsigned     sent;
  longint unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // transactions are seen with pre-edge values on both sides
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) sb.note_input(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tdata_o[62:0], m_axis_tdata_o[125:63], m_axis_tuser_o);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic send_item(bit [15:0] v, bit last);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent++;
  endtask

  function automatic bit [15:0] draw_value();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 1) return 16'd0;
    if (k < 40) return 16'($urandom_range(1, 16));
    if (k < 60) return 16'(($urandom_range(1, 12)) * ($urandom_range(1, 12)) * ($urandom_range(1, 7)));
    return 16'($urandom_range(1, 65535));
  endfunction

  initial begin : drive_input
    int unsigned     n;
    int unsigned     k;
    bit [15:0]       v;
    bit              one_val;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tlast_i = 1'b0;
    no_gaps = 0;
    sent = 0;
    cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed sets
    send_item(16'd1, 1);
    send_item(16'd65535, 1);
    send_item(16'd0, 1);
    send_item(16'd2, 0); send_item(16'd3, 0); send_item(16'd6, 1);
    send_item(16'd4, 0); send_item(16'd0, 0); send_item(16'd4, 1);
    send_item(16'd65521, 0); send_item(16'd65519, 0); send_item(16'd65497, 0);
    send_item(16'd65479, 0); send_item(16'd65449, 1);
    send_item(16'h5555, 0); send_item(16'hAAAA, 1);
    send_item(16'd7, 0); send_item(16'd7, 0); send_item(16'd7, 1);
    send_item(16'd32768, 0); send_item(16'd1, 1);

    while (sent < N_ITEMS) begin
      if ($urandom_range(0, 9) == 0) no_gaps = ~no_gaps;
      k = $urandom_range(0, 99);
      if (k < 80) n = $urandom_range(1, 6);
      else if (k < 97) n = $urandom_range(7, 30);
      else n = $urandom_range(MAX_COUNT - 8, MAX_COUNT + 4);
      one_val = (n > 30) && $urandom_range(0, 1);
      for (int i = 0; i < n; i++) begin
        v = one_val ? 16'(1 << $urandom_range(0, 3)) : draw_value();
        send_item(v, i == n - 1);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin : drive_output
    int unsigned stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

endmodule
`default_nettype wire
